### hw/rtl/cssts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clock sync slave timestamp package
// Shared transaction types, command codes, register indexes and the
// classified queue entry passed from the front end to the back end.
// ----------------------------------------------------------------------------
package cssts_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   // Command codes of an input transaction.
   localparam logic [1:0] CMD_UPDATE     = 2'd0;
   localparam logic [1:0] CMD_CONV_SLAVE = 2'd1;
   localparam logic [1:0] CMD_CONV_OBS   = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_TAG_TO_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TICKS_TO_TAG = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_JUMP_THRESH  = 2'd2;

   typedef enum logic [1:0] {
      KIND_UPDATE,
      KIND_CONV_SLAVE,
      KIND_CONV_OBS,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] time_tag;
      logic [63:0] ticks;
   } req_type;

   typedef struct packed {
      logic [63:0] tag_out;
      logic        slave_jumped;
   } rsp_type;

   typedef struct packed {
      logic [63:0] tag_to_ticks_ratio;
      logic [63:0] ticks_to_tag_ratio;
      logic [31:0] jump_threshold;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] time_tag;
      logic [63:0] ticks;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } q_head_type;

endpackage : cssts_pkg
`default_nettype wire

### hw/rtl/cssts_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clock sync slave timestamp front end
// Accepts request transactions, decodes the command into an operation kind
// and holds the classified entries in a short queue for the back end.
// ----------------------------------------------------------------------------
module cssts_front
   import cssts_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire req_type    req_data,
   output      q_head_type head,
   input  wire logic       pop
);

   // DEPTH must be at least two.
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   entry_type        wr_entry;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             do_pop;

   assign req_stall = (count_ff == FULL_CNT);
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && head.valid;

   always_comb begin
      wr_entry.time_tag = req_data.time_tag;
      wr_entry.ticks    = req_data.ticks;
      case (req_data.command)
         CMD_UPDATE:     wr_entry.kind = KIND_UPDATE;
         CMD_CONV_SLAVE: wr_entry.kind = KIND_CONV_SLAVE;
         CMD_CONV_OBS:   wr_entry.kind = KIND_CONV_OBS;
         default:        wr_entry.kind = KIND_NOP;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

endmodule : cssts_front
`default_nettype wire

### hw/rtl/cssts_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clock sync slave timestamp multiplier
// Two-stage 64 x 64 unsigned multiplier: four 32 x 32 partial products are
// registered, then summed into the registered 128-bit product.
// ----------------------------------------------------------------------------
module cssts_mul (
   input  wire logic          clock,
   input  wire logic          enable,
   input  wire logic [63:0]   a,
   input  wire logic [63:0]   b,
   output      logic [127:0]  prod
);

   logic [63:0]  ll_ff, ll_in;
   logic [63:0]  lh_ff, lh_in;
   logic [63:0]  hl_ff, hl_in;
   logic [63:0]  hh_ff, hh_in;
   logic [127:0] prod_ff, prod_in;

   always_comb begin
      ll_in   = ll_ff;
      lh_in   = lh_ff;
      hl_in   = hl_ff;
      hh_in   = hh_ff;
      prod_in = prod_ff;
      if (enable) begin
         ll_in   = a[31:0]  * b[31:0];
         lh_in   = a[31:0]  * b[63:32];
         hl_in   = a[63:32] * b[31:0];
         hh_in   = a[63:32] * b[63:32];
         prod_in = {hh_ff, ll_ff} + {32'b0, lh_ff, 32'b0} + {32'b0, hl_ff, 32'b0};
      end
   end

   always_ff @(posedge clock) begin
      ll_ff   <= ll_in;
      lh_ff   <= lh_in;
      hl_ff   <= hl_in;
      hh_ff   <= hh_in;
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule : cssts_mul
`default_nettype wire

### hw/rtl/cssts_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clock sync slave timestamp back end
// Pipeline that scales master tags to ticks, commits the slave and observed
// offsets in a single stage, scales offset tick counts back to tags, and
// holds the result in the response register.
// ----------------------------------------------------------------------------
module cssts_back
   import cssts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire q_head_type head,
   output      logic       pop,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      rsp_type    rsp_data
);

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic        jumped;
      logic [63:0] word;
   } stage_type;

   stage_type    s1_ff, s1_in;
   stage_type    s2_ff, s2_in;
   stage_type    s3_ff, s3_in;
   stage_type    s4_ff, s4_in;
   stage_type    s5_ff, s5_in;
   stage_type    s6_ff, s6_in;
   stage_type    commit;
   logic [63:0]  s3_master_ff, s3_master_in;
   logic [63:0]  s3_observed_ff, s3_observed_in;
   logic [63:0]  slave_offset_ff, slave_offset_in;
   logic [63:0]  observed_offset_ff, observed_offset_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;
   logic [127:0] tag_prod;
   logic [127:0] conv_prod;
   logic [63:0]  slave_now;
   logic [63:0]  behind;
   logic         hold;
   logic         advance;
   logic         is_conv;

   // The whole pipeline moves together whenever the response register can load.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && head.valid;

   cssts_mul u_tag_mul (
      .clock  (clock),
      .enable (advance),
      .a      (head.entry.time_tag),
      .b      (cfg.tag_to_ticks_ratio),
      .prod   (tag_prod)
   );

   cssts_mul u_conv_mul (
      .clock  (clock),
      .enable (advance),
      .a      (s4_ff.word),
      .b      (cfg.ticks_to_tag_ratio),
      .prod   (conv_prod)
   );

   // Commit stage. The behind distance slave_now - master equals
   // slave_offset - observed modulo 2^64, so both compares run in parallel.
   always_comb begin
      slave_now          = s3_ff.word + slave_offset_ff;
      behind             = slave_offset_ff - s3_observed_ff;
      hold               = (s3_master_ff < slave_now) &&
                           (behind < {32'b0, cfg.jump_threshold});
      commit             = s3_ff;
      commit.jumped      = 1'b0;
      slave_offset_in    = slave_offset_ff;
      observed_offset_in = observed_offset_ff;
      case (s3_ff.kind)
         KIND_UPDATE: begin
            commit.jumped = !hold;
            if (advance && s3_ff.valid) begin
               observed_offset_in = s3_observed_ff;
               if (!hold) begin
                  slave_offset_in = s3_observed_ff;
               end
            end
         end
         KIND_CONV_SLAVE: commit.word = s3_ff.word + slave_offset_ff;
         KIND_CONV_OBS:   commit.word = s3_ff.word + observed_offset_ff;
         default:         commit.word = s3_ff.word;
      endcase
   end

   always_comb begin
      s1_in          = s1_ff;
      s2_in          = s2_ff;
      s3_in          = s3_ff;
      s4_in          = s4_ff;
      s5_in          = s5_ff;
      s6_in          = s6_ff;
      s3_master_in   = s3_master_ff;
      s3_observed_in = s3_observed_ff;
      if (advance) begin
         s1_in.valid    = head.valid;
         s1_in.kind     = head.entry.kind;
         s1_in.jumped   = 1'b0;
         s1_in.word     = head.entry.ticks;
         s2_in          = s1_ff;
         s3_in          = s2_ff;
         s3_master_in   = tag_prod[127:64];
         s3_observed_in = tag_prod[127:64] - s2_ff.word;
         s4_in          = commit;
         s5_in          = s4_ff;
         s6_in          = s5_ff;
      end
   end

   assign is_conv = (s6_ff.kind == KIND_CONV_SLAVE) || (s6_ff.kind == KIND_CONV_OBS);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = s6_ff.valid;
         if (s6_ff.valid) begin
            rsp_data_in.tag_out      = is_conv ? conv_prod[95:32] : '0;
            rsp_data_in.slave_jumped = s6_ff.jumped && (s6_ff.kind == KIND_UPDATE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff              <= '0;
         s2_ff              <= '0;
         s3_ff              <= '0;
         s4_ff              <= '0;
         s5_ff              <= '0;
         s6_ff              <= '0;
         s3_master_ff       <= '0;
         s3_observed_ff     <= '0;
         rsp_data_ff        <= '0;
         rsp_valid_ff       <= 1'b0;
         slave_offset_ff    <= '0;
         observed_offset_ff <= '0;
      end else begin
         s1_ff              <= s1_in;
         s2_ff              <= s2_in;
         s3_ff              <= s3_in;
         s4_ff              <= s4_in;
         s5_ff              <= s5_in;
         s6_ff              <= s6_in;
         s3_master_ff       <= s3_master_in;
         s3_observed_ff     <= s3_observed_in;
         rsp_data_ff        <= rsp_data_in;
         rsp_valid_ff       <= rsp_valid_in;
         slave_offset_ff    <= slave_offset_in;
         observed_offset_ff <= observed_offset_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : cssts_back
`default_nettype wire

### hw/rtl/clock_sync_slave_timestamp_unit.sv
// A response passes through the queue, stages s1 to s6 and the response register.
// One transaction per cycle when unstalled; one commit stage reads and writes offsets.
// Each 64 x 64 scaling uses four 32 x 32 partial products over two pipeline stages.
// Reset is synchronous: it empties the queue and pipeline and clears offsets and registers.
// No clearing pass is needed; requests are taken from the first cycle after reset.
`default_nettype none
// ----------------------------------------------------------------------------
// Clock sync slave timestamp unit
// Slave clock locked to a remote master: master tag updates adjust the slave
// and observed offsets, and tick counts are converted to 32.32 time tags.
// ----------------------------------------------------------------------------
module clock_sync_slave_timestamp_unit
   import cssts_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire req_type                req_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      rsp_type                rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   q_head_type queue_head;
   logic       queue_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_TAG_TO_TICKS: cfg_in.tag_to_ticks_ratio = csr_wdata;
            REG_TICKS_TO_TAG: cfg_in.ticks_to_tag_ratio = csr_wdata;
            REG_JUMP_THRESH:  cfg_in.jump_threshold     = csr_wdata[31:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cssts_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .head      (queue_head),
      .pop       (queue_pop)
   );

   cssts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (queue_head),
      .pop       (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // Only an update transaction can report a jump, and updates carry a zero tag.
   a_jump_has_zero_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.slave_jumped |-> rsp_data.tag_out == '0)
      else $error("Jumped response carries a nonzero tag.");

   // A stalled response freezes the back end, so the queue must not drain.
   a_no_pop_while_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !queue_pop)
      else $error("Queue popped while the response was stalled.");

   // Reset empties both the queue and the response register.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid && !queue_head.valid)
      else $error("Block not empty after reset.");
`endif

endmodule : clock_sync_slave_timestamp_unit
`default_nettype wire
